[hdl/wsdf_pkg.sv]
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; the parser, output stage, top level and testbench use this package by scoped names.
package wsdf_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN7,
    PH_EXT16,
    PH_EXT64,
    PH_MASK,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD,
    KIND_EMPTY,
    KIND_TOO_LARGE
  } kind_t;

  localparam logic [3:0]  OPCODE_MASK = 4'hF;
  localparam logic [6:0]  LEN_EXT16   = 7'd126;
  localparam logic [6:0]  LEN_EXT64   = 7'd127;
  localparam logic [31:0] LEN_MARK    = 32'hFFFF_FFFF;
  localparam logic [30:0] LEN_ERR     = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [3:0]  frame_opcode;
    logic [30:0] frame_length;
    kind_t       result_kind;
    logic        last_of_frame;
  } result_t;

endpackage

[hdl/wsdf_in_if.sv]
// Input channel of the deframer: one received byte per beat.
// Depends on nothing.
interface wsdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_start;

  modport source(output valid, rx_byte, buffer_start, input ready);
  modport sink(input valid, rx_byte, buffer_start, output ready);
endinterface

[hdl/wsdf_out_if.sv]
// Result channel of the deframer: one payload byte, notice or error per beat.
// Depends on nothing.
interface wsdf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [3:0]  frame_opcode;
  logic [30:0] frame_length;
  logic [1:0]  result_kind;
  logic        last_of_frame;

  modport source(output valid, payload_byte, frame_opcode, frame_length, result_kind,
                 last_of_frame, input ready);
  modport sink(input valid, payload_byte, frame_opcode, frame_length, result_kind,
               last_of_frame, output ready);
endinterface

[hdl/wsdf_parser.sv]
// Input register, frame header state machine and payload unmasking.
// Depends on wsdf_pkg and wsdf_in_if; hands at most one result per step to the output stage.
module wsdf_parser (
  input  logic               clk,
  input  logic               rst,
  wsdf_in_if.sink            rx,
  input  logic               res_ready,
  output logic               res_valid,
  output wsdf_pkg::result_t  res
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_start;
  logic        fire;

  wsdf_pkg::phase_t phase, phase_next;
  logic [2:0]  hdr_count, hdr_count_next;
  logic [31:0] length, length_next;
  logic [31:0] mask_key, mask_key_next;
  logic        mask_en, mask_en_next;
  logic [3:0]  opcode, opcode_next;
  logic [30:0] pay_count, pay_count_next;

  assign fire     = in_valid && res_ready;
  assign rx.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte  <= rx.rx_byte;
      in_start <= rx.buffer_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= wsdf_pkg::PH_IDLE;
      hdr_count <= '0;
      length    <= '0;
      mask_key  <= '0;
      mask_en   <= 1'b0;
      opcode    <= '0;
      pay_count <= '0;
    end else if (fire) begin
      phase     <= phase_next;
      hdr_count <= hdr_count_next;
      length    <= length_next;
      mask_key  <= mask_key_next;
      mask_en   <= mask_en_next;
      opcode    <= opcode_next;
      pay_count <= pay_count_next;
    end
  end

  always_comb begin
    logic        len_done;
    logic        key_done;
    logic [31:0] len_val;
    logic [31:0] ext64_val;
    logic [7:0]  key_byte;
    logic        is_last;

    len_done  = 1'b0;
    key_done  = 1'b0;
    len_val   = length;
    ext64_val = length;
    key_byte  = '0;
    is_last   = 1'b0;

    phase_next     = phase;
    hdr_count_next = hdr_count;
    length_next    = length;
    mask_key_next  = mask_key;
    mask_en_next   = mask_en;
    opcode_next    = opcode;
    pay_count_next = pay_count;

    res_valid         = 1'b0;
    res.payload_byte  = '0;
    res.frame_opcode  = opcode;
    res.frame_length  = '0;
    res.result_kind   = wsdf_pkg::KIND_PAYLOAD;
    res.last_of_frame = 1'b0;

    if (in_start) begin
      opcode_next    = in_byte[3:0] & wsdf_pkg::OPCODE_MASK;
      hdr_count_next = '0;
      length_next    = '0;
      mask_key_next  = '0;
      mask_en_next   = 1'b0;
      pay_count_next = '0;
      phase_next     = wsdf_pkg::PH_LEN7;
    end else begin
      unique case (phase)
        wsdf_pkg::PH_LEN7: begin
          mask_en_next   = in_byte[7];
          hdr_count_next = '0;
          length_next    = '0;
          if (in_byte[6:0] == wsdf_pkg::LEN_EXT16) begin
            phase_next = wsdf_pkg::PH_EXT16;
          end else if (in_byte[6:0] == wsdf_pkg::LEN_EXT64) begin
            phase_next = wsdf_pkg::PH_EXT64;
          end else begin
            len_val     = {25'd0, in_byte[6:0]};
            length_next = len_val;
            len_done    = 1'b1;
          end
        end
        wsdf_pkg::PH_EXT16: begin
          len_val     = {16'd0, length[7:0], in_byte};
          length_next = len_val;
          if (hdr_count != 3'd0) begin
            hdr_count_next = '0;
            len_done       = 1'b1;
          end else begin
            hdr_count_next = 3'(hdr_count + 3'd1);
          end
        end
        wsdf_pkg::PH_EXT64: begin
          if (!hdr_count[2]) begin
            ext64_val = length | {24'd0, in_byte};
            if (hdr_count == 3'd3) begin
              ext64_val = (ext64_val != '0) ? wsdf_pkg::LEN_MARK : '0;
            end
          end else if (length != wsdf_pkg::LEN_MARK) begin
            ext64_val = {length[23:0], in_byte};
          end
          length_next = ext64_val;
          len_val     = ext64_val;
          if (hdr_count == 3'd7) begin
            hdr_count_next = '0;
            if (ext64_val[31]) begin
              res_valid         = 1'b1;
              res.frame_length  = wsdf_pkg::LEN_ERR;
              res.result_kind   = wsdf_pkg::KIND_TOO_LARGE;
              res.last_of_frame = 1'b1;
              phase_next        = wsdf_pkg::PH_IDLE;
            end else begin
              len_done = 1'b1;
            end
          end else begin
            hdr_count_next = 3'(hdr_count + 3'd1);
          end
        end
        wsdf_pkg::PH_MASK: begin
          mask_key_next = {mask_key[23:0], in_byte};
          if (hdr_count >= 3'd3) begin
            hdr_count_next = '0;
            key_done       = 1'b1;
          end else begin
            hdr_count_next = 3'(hdr_count + 3'd1);
          end
        end
        wsdf_pkg::PH_PAYLOAD: begin
          case (pay_count[1:0])
            2'd0:    key_byte = mask_key[31:24];
            2'd1:    key_byte = mask_key[23:16];
            2'd2:    key_byte = mask_key[15:8];
            default: key_byte = mask_key[7:0];
          endcase
          if (!mask_en) begin
            key_byte = '0;
          end
          is_last           = ({1'b0, pay_count} + 32'd1) >= length;
          res_valid         = 1'b1;
          res.payload_byte  = in_byte ^ key_byte;
          res.frame_length  = length[30:0];
          res.result_kind   = wsdf_pkg::KIND_PAYLOAD;
          res.last_of_frame = is_last;
          pay_count_next    = 31'(pay_count + 31'd1);
          if (is_last) begin
            phase_next = wsdf_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_next = wsdf_pkg::PH_IDLE;
        end
      endcase

      if (len_done) begin
        if (mask_en_next) begin
          hdr_count_next = '0;
          mask_key_next  = '0;
          phase_next     = wsdf_pkg::PH_MASK;
        end else begin
          key_done = 1'b1;
        end
      end

      if (key_done) begin
        if (len_val == '0) begin
          res_valid         = 1'b1;
          res.frame_length  = '0;
          res.result_kind   = wsdf_pkg::KIND_EMPTY;
          res.last_of_frame = 1'b1;
          phase_next        = wsdf_pkg::PH_IDLE;
        end else begin
          pay_count_next = '0;
          phase_next     = wsdf_pkg::PH_PAYLOAD;
        end
      end
    end

    if (!fire) begin
      res_valid = 1'b0;
    end
  end

endmodule

[hdl/wsdf_out_stage.sv]
// Result register with one skid entry; upstream ready comes from a flop.
// Depends on wsdf_pkg and wsdf_out_if.
module wsdf_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  input  wsdf_pkg::result_t  res,
  output logic               res_ready,
  wsdf_out_if.source         result
);

  logic              main_valid;
  logic              skid_valid;
  wsdf_pkg::result_t main_data;
  wsdf_pkg::result_t skid_data;
  logic              push;
  logic              pop;

  assign res_ready = !skid_valid;
  assign push      = res_valid && !skid_valid;
  assign pop       = main_valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !result.ready) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push) begin
      if (main_valid && !result.ready) begin
        skid_data <= res;
      end else begin
        main_data <= res;
      end
    end
  end

  assign result.valid         = main_valid;
  assign result.payload_byte  = main_data.payload_byte;
  assign result.frame_opcode  = main_data.frame_opcode;
  assign result.frame_length  = main_data.frame_length;
  assign result.result_kind   = main_data.result_kind;
  assign result.last_of_frame = main_data.last_of_frame;

endmodule

[hdl/websocket_frame_deframer.sv]
// WebSocket receive deframer: takes one byte per beat and returns unmasked payload bytes,
// an empty-frame notice or a length-too-large error. Sustains one byte per clock while the
// result port is not stalled; a byte's result reaches the result port through the input
// register, then the result register, and the one-entry skid lets the input keep flowing
// while a result waits. A beat with buffer_start set restarts header parsing. No clearing pass after reset.
// Depends on wsdf_pkg, wsdf_in_if, wsdf_out_if, wsdf_parser and wsdf_out_stage.
module websocket_frame_deframer (
  input  logic       clk,
  input  logic       rst,
  wsdf_in_if.sink    rx,
  wsdf_out_if.source result
);

  logic              res_valid;
  logic              res_ready;
  wsdf_pkg::result_t res;

  wsdf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  wsdf_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .result    (result)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_ready)
    else $error("result produced while output stage is full");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.result_kind == wsdf_pkg::KIND_TOO_LARGE
      |-> res.frame_length == wsdf_pkg::LEN_ERR && res.payload_byte == 8'd0
          && res.last_of_frame)
    else $error("malformed length error result");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for websocket_frame_deframer: directed frames, then random frames,
// checked beat by beat against an in-bench frame parser. Depends on wsdf_pkg, the interfaces and the deframer.
module testbench;

  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int PHASE_BEATS     = 225;
  localparam int NUM_PHASES      = 6;
  localparam int PRESSURE_PHASE  = 4;
  localparam int MAX_REPORTS     = 40;
  localparam int MAX_CHUNK       = 48;

  typedef struct packed {
    logic [7:0] b;
    logic       s;
  } beat_t;

  typedef struct packed {
    logic [7:0]      b;
    logic            s;
    logic            typed;
    logic [7:0]      pb;
    logic [3:0]      op;
    logic [30:0]     len;
    wsdf_pkg::kind_t kind;
    logic            last;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  always #1 clk = ~clk;

  wsdf_in_if  rx_if ();
  wsdf_out_if res_if ();

  websocket_frame_deframer i_dut (
    .clk(clk),
    .rst(rst),
    .rx(rx_if),
    .result(res_if)
  );

  dir_row_t directed_rows [0:25] = '{
    '{8'hA5, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h8A, 1'b1, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h80, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h12, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h34, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h56, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h78, 1'b0, 1'b1, 8'h00, 4'hA, 31'd0,         wsdf_pkg::KIND_EMPTY,     1'b1},
    '{8'h3C, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h71, 1'b1, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h02, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'hFF, 1'b0, 1'b1, 8'hFF, 4'h1, 31'd2,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h0F, 1'b1, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h7F, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h80, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h00, 1'b0, 1'b1, 8'h00, 4'hF, 31'h7FFF_FFFF, wsdf_pkg::KIND_TOO_LARGE, 1'b1},
    '{8'h00, 1'b1, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h7E, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'h01, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0},
    '{8'hC3, 1'b0, 1'b0, 8'h00, 4'h0, 31'd0,         wsdf_pkg::KIND_PAYLOAD,   1'b0}
  };

  wsdf_pkg::phase_t parse_ph;
  logic [2:0]       hdr_cnt;
  logic [31:0]      len_acc;
  logic [31:0]      key_acc;
  logic             masked;
  logic [3:0]       op_nib;
  logic [30:0]      pay_pos;

  wsdf_pkg::result_t deframed_q [$];
  beat_t             byte_feed [$];
  int                fed_beats;
  int                send_idle_pct;
  int                recv_stall_pct;
  logic              hold_go;
  int                hold_count = 0;
  int                idle_cycles = 0;
  int                mismatch_count = 0;
  wsdf_pkg::result_t want;

  function automatic logic start_payload(output wsdf_pkg::result_t r);
    r = '0;
    if (len_acc == 32'd0) begin
      r.frame_opcode  = op_nib;
      r.result_kind   = wsdf_pkg::KIND_EMPTY;
      r.last_of_frame = 1'b1;
      parse_ph        = wsdf_pkg::PH_IDLE;
      return 1'b1;
    end
    pay_pos  = '0;
    parse_ph = wsdf_pkg::PH_PAYLOAD;
    return 1'b0;
  endfunction

  function automatic logic close_length(output wsdf_pkg::result_t r);
    r = '0;
    if (masked) begin
      hdr_cnt  = '0;
      key_acc  = '0;
      parse_ph = wsdf_pkg::PH_MASK;
      return 1'b0;
    end
    return start_payload(r);
  endfunction

  function automatic logic deframe_byte(input logic [7:0] b, input logic s,
                                        output wsdf_pkg::result_t r, output logic ign);
    logic [7:0] kb;
    logic       last;
    r   = '0;
    ign = 1'b0;
    if (s) begin
      op_nib   = b[3:0] & wsdf_pkg::OPCODE_MASK;
      hdr_cnt  = '0;
      len_acc  = '0;
      key_acc  = '0;
      masked   = 1'b0;
      pay_pos  = '0;
      parse_ph = wsdf_pkg::PH_LEN7;
      return 1'b0;
    end
    case (parse_ph)
      wsdf_pkg::PH_LEN7: begin
        masked  = b[7];
        hdr_cnt = '0;
        len_acc = '0;
        if (b[6:0] == wsdf_pkg::LEN_EXT16) begin
          parse_ph = wsdf_pkg::PH_EXT16;
          return 1'b0;
        end
        if (b[6:0] == wsdf_pkg::LEN_EXT64) begin
          parse_ph = wsdf_pkg::PH_EXT64;
          return 1'b0;
        end
        len_acc = {25'd0, b[6:0]};
        return close_length(r);
      end
      wsdf_pkg::PH_EXT16: begin
        len_acc = {16'd0, len_acc[7:0], b};
        if (hdr_cnt >= 3'd1) begin
          hdr_cnt = '0;
          return close_length(r);
        end
        hdr_cnt++;
        return 1'b0;
      end
      wsdf_pkg::PH_EXT64: begin
        if (hdr_cnt < 3'd4) begin
          len_acc |= {24'd0, b};
          if (hdr_cnt == 3'd3) len_acc = (len_acc != 32'd0) ? wsdf_pkg::LEN_MARK : 32'd0;
        end else if (len_acc != wsdf_pkg::LEN_MARK) begin
          len_acc = {len_acc[23:0], b};
        end
        if (hdr_cnt >= 3'd7) begin
          hdr_cnt = '0;
          if (len_acc[31]) begin
            r.frame_opcode  = op_nib;
            r.frame_length  = wsdf_pkg::LEN_ERR;
            r.result_kind   = wsdf_pkg::KIND_TOO_LARGE;
            r.last_of_frame = 1'b1;
            parse_ph        = wsdf_pkg::PH_IDLE;
            return 1'b1;
          end
          return close_length(r);
        end
        hdr_cnt++;
        return 1'b0;
      end
      wsdf_pkg::PH_MASK: begin
        key_acc = {key_acc[23:0], b};
        if (hdr_cnt >= 3'd3) begin
          hdr_cnt = '0;
          return start_payload(r);
        end
        hdr_cnt++;
        return 1'b0;
      end
      wsdf_pkg::PH_PAYLOAD: begin
        kb   = masked ? 8'(key_acc >> (24 - 8 * int'(pay_pos[1:0]))) : 8'h00;
        last = (({1'b0, pay_pos} + 32'd1) >= len_acc);
        r.payload_byte  = b ^ kb;
        r.frame_opcode  = op_nib;
        r.frame_length  = len_acc[30:0];
        r.result_kind   = wsdf_pkg::KIND_PAYLOAD;
        r.last_of_frame = last;
        pay_pos         = pay_pos + 31'd1;
        if (last) parse_ph = wsdf_pkg::PH_IDLE;
        return 1'b1;
      end
      default: begin
        ign      = 1'b1;
        parse_ph = wsdf_pkg::PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned exp_val);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, exp_val, $realtime);
  endtask

  task automatic send_beat(input logic [7:0] b, input logic s, input logic typed,
                           input wsdf_pkg::result_t typed_r);
    wsdf_pkg::result_t r;
    logic              got;
    logic              ign;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(negedge clk);
    end
    rx_if.valid        <= 1'b1;
    rx_if.rx_byte      <= b;
    rx_if.buffer_start <= s;
    do @(posedge clk); while (!rx_if.ready);
    got = deframe_byte(b, s, r, ign);
    if (typed) deframed_q.push_back(typed_r);
    else if (got) deframed_q.push_back(r);
    if (!ign) fed_beats++;
    @(negedge clk);
  endtask

  task automatic queue_frame();
    beat_t       fb [$];
    logic [31:0] upper;
    logic [31:0] lower;
    logic [63:0] len64;
    logic [31:0] key;
    logic [6:0]  l7;
    logic        msk;
    logic        oversize;
    int          roll;
    int          n;
    int          cut;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      n = $urandom_range(1, 12);
      repeat (n) byte_feed.push_back({8'($urandom), ($urandom_range(0, 7) == 0)});
      return;
    end
    upper    = '0;
    lower    = '0;
    oversize = 1'b0;
    roll     = $urandom_range(0, 99);
    if (roll < 45) begin
      if ($urandom_range(0, 9) == 0) lower = 32'd0;
      else if ($urandom_range(0, 19) == 0) lower = $urandom_range(100, 125);
      else lower = $urandom_range(1, 20);
      l7 = lower[6:0];
    end else if (roll < 70) begin
      if ($urandom_range(0, 7) == 0)
        lower = ($urandom_range(0, 3) == 0) ? 32'h0000_FFFF : $urandom_range(0, 65535);
      else
        lower = $urandom_range(0, 40);
      l7 = wsdf_pkg::LEN_EXT16;
    end else if (roll < 85) begin
      if ($urandom_range(0, 7) == 0)
        lower = ($urandom_range(0, 3) == 0) ? 32'h7FFF_FFFF : ($urandom & 32'h7FFF_FFFF);
      else
        lower = $urandom_range(0, 40);
      l7 = wsdf_pkg::LEN_EXT64;
    end else begin
      upper = $urandom;
      lower = $urandom;
      if ($urandom_range(0, 1)) upper[$urandom_range(0, 31)] = 1'b1;
      else lower[31] = 1'b1;
      oversize = 1'b1;
      l7 = wsdf_pkg::LEN_EXT64;
    end
    len64 = {upper, lower};
    msk   = 1'($urandom_range(0, 1));
    key   = $urandom;
    fb.push_back({8'($urandom), 1'b1});
    fb.push_back({msk, l7, 1'b0});
    if (l7 == wsdf_pkg::LEN_EXT16) begin
      fb.push_back({lower[15:8], 1'b0});
      fb.push_back({lower[7:0], 1'b0});
    end
    if (l7 == wsdf_pkg::LEN_EXT64)
      for (int i = 7; i >= 0; i--) fb.push_back({len64[8 * i +: 8], 1'b0});
    if (msk)
      for (int i = 3; i >= 0; i--) fb.push_back({key[8 * i +: 8], 1'b0});
    if (oversize) n = $urandom_range(0, 6);
    else if (lower > MAX_CHUNK) n = $urandom_range(1, MAX_CHUNK);
    else n = int'(lower);
    repeat (n) fb.push_back({8'($urandom), 1'b0});
    if ($urandom_range(0, 11) == 0) begin
      cut = $urandom_range(1, fb.size());
      while (fb.size() > cut) void'(fb.pop_back());
    end
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 4)) fb.push_back({8'($urandom), 1'b0});
    foreach (fb[i]) byte_feed.push_back(fb[i]);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (hold_go && hold_count < HOLD_CYCLES) begin
      res_if.ready <= 1'b0;
      hold_count   <= hold_count + 1;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (deframed_q.size() == 0) begin
        report_mismatch("result with nothing pending", res_if.payload_byte, 0);
      end else begin
        want = deframed_q.pop_front();
        if (res_if.payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", res_if.payload_byte, want.payload_byte);
        if (res_if.frame_opcode !== want.frame_opcode)
          report_mismatch("frame_opcode", res_if.frame_opcode, want.frame_opcode);
        if (res_if.frame_length !== want.frame_length)
          report_mismatch("frame_length", res_if.frame_length, want.frame_length);
        if (res_if.result_kind !== 2'(want.result_kind))
          report_mismatch("result_kind", res_if.result_kind, want.result_kind);
        if (res_if.last_of_frame !== want.last_of_frame)
          report_mismatch("last_of_frame", res_if.last_of_frame, want.last_of_frame);
      end
    end
  end

  always @(posedge clk) begin
    if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("FAIL websocket_frame_deframer");
      $finish;
    end
  end

  initial begin
    beat_t bt;
    int    target;
    rst                = 1'b1;
    rx_if.valid        = 1'b0;
    rx_if.rx_byte      = 8'h00;
    rx_if.buffer_start = 1'b0;
    hold_go            = 1'b0;
    fed_beats          = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    parse_ph           = wsdf_pkg::PH_IDLE;
    hdr_cnt            = '0;
    len_acc            = '0;
    key_acc            = '0;
    masked             = 1'b0;
    op_nib             = '0;
    pay_pos            = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].b, directed_rows[i].s, directed_rows[i].typed,
                {directed_rows[i].pb, directed_rows[i].op, directed_rows[i].len,
                 directed_rows[i].kind, directed_rows[i].last});

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1: begin
          send_idle_pct = 75;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 75;
        end
        3: begin
          send_idle_pct = 23;
          recv_stall_pct <= 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
      endcase
      if (p == PRESSURE_PHASE) hold_go <= 1'b1;
      target = fed_beats + PHASE_BEATS;
      while (fed_beats < target) begin
        queue_frame();
        while (byte_feed.size() != 0) begin
          bt = byte_feed.pop_front();
          send_beat(bt.b, bt.s, 1'b0, '0);
        end
      end
    end
    rx_if.valid <= 1'b0;

    wait (deframed_q.size() == 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("PASS websocket_frame_deframer");
    else $display("FAIL websocket_frame_deframer");
    $finish;
  end

endmodule
